// File: design/rau_pkg.sv
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  // small multiplier operand: operand width plus room for an unsigned magnitude
  localparam int SW    = OPERAND_WIDTH + 2;
  localparam int MCW   = $clog2(SW + 1);
  localparam int XW    = 64;
  localparam int DCW   = $clog2(XW + 1);
  localparam int GKW   = $clog2(XW);
  localparam int NUM_W = 34;
  localparam int DEN_W = 32;
  localparam int QD    = 2;
  localparam int QAW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_GT   = 3'd2;
  localparam logic [2:0] CMD_EQ   = 3'd3;
  localparam logic [2:0] CMD_NORM = 3'd4;

  typedef struct packed {
    logic [2:0]                      cmd;
    logic signed [OPERAND_WIDTH-1:0] left_num;
    logic signed [OPERAND_WIDTH-1:0] left_den;
    logic signed [OPERAND_WIDTH-1:0] right_num;
    logic signed [OPERAND_WIDTH-1:0] right_den;
  } req_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic signed [DEN_W-1:0] res_den;
    logic                    cmp_flag;
    logic                    error;
  } res_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_GT,
    OP_NORM,
    OP_FIXED
  } job_op_t;

  typedef struct packed {
    job_op_t op;
    req_t    args;
    logic    flag;
    logic    err;
  } job_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_ADD_M1,
    B_ADD_M2,
    B_ADD_M3,
    B_GT_M1,
    B_GT_M2,
    B_SUB_GCD,
    B_SUB_DIV,
    B_SUB_MUL,
    B_SUB_DV1,
    B_SUB_DV2,
    B_SUB_M1,
    B_SUB_M2,
    B_FORM,
    B_MOD,
    B_RED,
    B_RGCD,
    B_DIVN,
    B_DIVD,
    B_OUT
  } back_state_t;

  function automatic logic [XW-1:0] sx(input logic signed [OPERAND_WIDTH-1:0] v);
    return XW'(v);
  endfunction

endpackage

// File: design/rational_arithmetic_unit.sv
// Equal, unused codes and zero-denominator errors go straight to the result; greater, add,
// subtract and normalize step through the multiplier, divider and gcd units as needed; the
// closing gcd reduction runs only when both parts are positive.
// The back end works on one item at a time; a two-beat queue takes new items
// while a result is computed. The receiver cannot stall: done lasts one cycle.
// Reset (rst, synchronous) empties the queue and returns the sequencer to idle.
module rational_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rau_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output rau_pkg::res_t result
);
  import rau_pkg::*;

  logic full;
  logic push;
  logic pop;
  logic valid;
  job_t wr_job;
  job_t rd_job;

  rau_front u_front (
    .start (start),
    .req   (req),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .job   (wr_job)
  );

  rau_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .full   (full),
    .valid  (valid),
    .rd_job (rd_job)
  );

  rau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .valid  (valid),
    .job    (rd_job),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

// File: design/rau_front.sv
module rau_front (
  input  logic          start,
  input  rau_pkg::req_t req,
  input  logic          full,
  output logic          busy,
  output logic          push,
  output rau_pkg::job_t job
);
  import rau_pkg::*;

  logic ld_zero;
  logic rd_zero;

  assign busy    = full;
  assign push    = start && !full;
  assign ld_zero = (req.left_den == '0);
  assign rd_zero = (req.right_den == '0);

  always_comb begin
    job.args = req;
    job.flag = 1'b0;
    job.err  = 1'b0;
    job.op   = OP_FIXED;
    case (req.cmd)
      CMD_ADD: begin
        job.op = OP_ADD;
      end
      CMD_SUB: begin
        if (ld_zero || rd_zero) begin
          job.err = 1'b1;
        end else begin
          job.op = OP_SUB;
        end
      end
      CMD_GT: begin
        job.op = OP_GT;
      end
      CMD_EQ: begin
        job.flag = (req.left_num == req.right_num) && (req.left_den == req.right_den);
      end
      CMD_NORM: begin
        if (ld_zero) begin
          job.err = 1'b1;
        end else begin
          job.op = OP_NORM;
        end
      end
      default: begin
        job.op = OP_FIXED;
      end
    endcase
  end

endmodule

// File: design/rau_fifo.sv
module rau_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rau_pkg::job_t wr_job,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output rau_pkg::job_t rd_job
);
  import rau_pkg::*;

  job_t           entries [QD];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] cnt;

  assign full   = (cnt == QCW'(QD));
  assign valid  = (cnt != '0);
  assign rd_job = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QD - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QD - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr_job;
    end
  end

endmodule

// File: design/rau_back.sv
module rau_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  input  rau_pkg::job_t job,
  output logic          pop,
  output logic          done,
  output rau_pkg::res_t result
);
  import rau_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic        fresh;

  logic signed [OPERAND_WIDTH-1:0] ln;
  logic signed [OPERAND_WIDTH-1:0] ld;
  logic signed [OPERAND_WIDTH-1:0] rn;
  logic signed [OPERAND_WIDTH-1:0] rd;
  logic [XW-1:0] n;
  logic [XW-1:0] d;
  logic [XW-1:0] t;
  logic [XW-1:0] u;
  logic          flag;
  logic          err;

  // shift-add multiplier, small operand two's complement
  logic [XW-1:0]  mul_a;
  logic [SW-1:0]  mul_b;
  logic [XW-1:0]  macc;
  logic [XW-1:0]  mcs;
  logic [SW-1:0]  mp;
  logic [MCW-1:0] mcnt;
  logic           mul_done;

  // restoring divider on magnitudes
  logic [XW-1:0]  div_a;
  logic [XW-1:0]  div_b;
  logic           div_sgn;
  logic [XW-1:0]  dq;
  logic [XW-1:0]  drem;
  logic [XW-1:0]  dd;
  logic           qneg;
  logic           rneg;
  logic [DCW-1:0] dcnt;
  logic           div_done;
  logic [XW:0]    rem2;
  logic           rem_ge;
  logic [XW-1:0]  quo;
  logic [XW-1:0]  remv;
  logic           a_neg;
  logic           b_neg;

  // binary gcd
  logic [XW-1:0]  gcd_a;
  logic [XW-1:0]  gcd_b;
  logic [XW-1:0]  ga;
  logic [XW-1:0]  gb;
  logic [GKW-1:0] gk;
  logic           gcd_done;
  logic [XW-1:0]  gval;

  logic signed [OPERAND_WIDTH:0] lde;
  logic signed [OPERAND_WIDTH:0] rde;
  logic [OPERAND_WIDTH:0]        al;
  logic [OPERAND_WIDTH:0]        ar;
  logic                          form_gt;
  logic                          d_m1;
  logic                          both_pos;

  assign lde      = (OPERAND_WIDTH + 1)'(ld);
  assign rde      = (OPERAND_WIDTH + 1)'(rd);
  assign al       = lde[OPERAND_WIDTH] ? -lde : lde;
  assign ar       = rde[OPERAND_WIDTH] ? -rde : rde;
  assign form_gt  = $signed(n) > $signed(d);
  assign d_m1     = (d == '1);
  assign both_pos = ($signed(n) > 0) && ($signed(d) > 0);

  assign mul_done = !fresh && (mcnt == MCW'(SW));
  assign div_done = !fresh && (dcnt == DCW'(XW));
  assign gcd_done = !fresh && (ga == gb);
  assign gval     = ga << gk;
  assign rem2     = {drem, dq[XW-1]};
  assign rem_ge   = rem2 >= {1'b0, dd};
  assign quo      = qneg ? -dq : dq;
  assign remv     = rneg ? -drem : drem;
  assign a_neg    = div_sgn && div_a[XW-1];
  assign b_neg    = div_sgn && div_b[XW-1];

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_a   = '0;
    div_b   = '0;
    div_sgn = 1'b1;
    gcd_a   = n;
    gcd_b   = d;
    case (state)
      B_ADD_M1, B_GT_M1: begin
        mul_a = sx(rd);
        mul_b = SW'(ln);
      end
      B_ADD_M2, B_GT_M2: begin
        mul_a = sx(ld);
        mul_b = SW'(rn);
      end
      B_ADD_M3: begin
        mul_a = sx(ld);
        mul_b = SW'(rd);
      end
      B_SUB_GCD: begin
        gcd_a = XW'(al);
        gcd_b = XW'(ar);
      end
      B_SUB_DIV: begin
        div_a   = XW'(al);
        div_b   = t;
        div_sgn = 1'b0;
      end
      B_SUB_MUL: begin
        mul_a = t;
        mul_b = SW'(ar);
      end
      B_SUB_DV1: begin
        div_a = d;
        div_b = sx(ld);
      end
      B_SUB_DV2: begin
        div_a = d;
        div_b = sx(rd);
      end
      B_SUB_M1: begin
        mul_a = t;
        mul_b = SW'(ln);
      end
      B_SUB_M2: begin
        mul_a = u;
        mul_b = SW'(rn);
      end
      B_MOD: begin
        div_a = n;
        div_b = d;
      end
      B_DIVN: begin
        div_a = n;
        div_b = t;
      end
      B_DIVD: begin
        div_a = d;
        div_b = t;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (valid) begin
          case (job.op)
            OP_ADD:  state_next = B_ADD_M1;
            OP_SUB:  state_next = B_SUB_GCD;
            OP_GT:   state_next = B_GT_M1;
            OP_NORM: state_next = B_FORM;
            default: state_next = B_OUT;
          endcase
        end
      end
      B_ADD_M1:  if (mul_done) state_next = B_ADD_M2;
      B_ADD_M2:  if (mul_done) state_next = B_ADD_M3;
      B_ADD_M3:  if (mul_done) state_next = B_RED;
      B_GT_M1:   if (mul_done) state_next = B_GT_M2;
      B_GT_M2:   if (mul_done) state_next = B_OUT;
      B_SUB_GCD: if (gcd_done) state_next = B_SUB_DIV;
      B_SUB_DIV: if (div_done) state_next = B_SUB_MUL;
      B_SUB_MUL: if (mul_done) state_next = B_SUB_DV1;
      B_SUB_DV1: if (div_done) state_next = B_SUB_DV2;
      B_SUB_DV2: if (div_done) state_next = B_SUB_M1;
      B_SUB_M1:  if (mul_done) state_next = B_SUB_M2;
      B_SUB_M2:  if (mul_done) state_next = B_FORM;
      B_FORM:    state_next = (form_gt && !d_m1) ? B_MOD : B_RED;
      B_MOD:     if (div_done) state_next = B_RED;
      B_RED:     state_next = both_pos ? B_RGCD : B_OUT;
      B_RGCD:    if (gcd_done) state_next = B_DIVN;
      B_DIVN:    if (div_done) state_next = B_DIVD;
      B_DIVD:    if (div_done) state_next = B_OUT;
      B_OUT:     state_next = B_IDLE;
      default:   state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop             = (state == B_IDLE) && valid;
    done            = (state == B_OUT);
    result.res_num  = n[NUM_W-1:0];
    result.res_den  = d[DEN_W-1:0];
    result.cmp_flag = flag;
    result.error    = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      fresh <= 1'b0;
    end else begin
      state <= state_next;
      fresh <= (state_next != state);
    end
  end

  // arithmetic units: load on the first cycle of a step, then iterate
  always_ff @(posedge clk) begin
    if (fresh) begin
      macc <= '0;
      mcs  <= mul_a;
      mp   <= mul_b;
      mcnt <= '0;
      dq   <= a_neg ? -div_a : div_a;
      dd   <= b_neg ? -div_b : div_b;
      drem <= '0;
      qneg <= a_neg ^ b_neg;
      rneg <= a_neg;
      dcnt <= '0;
      ga   <= gcd_a;
      gb   <= gcd_b;
      gk   <= '0;
    end else begin
      if (mcnt != MCW'(SW)) begin
        if (mp[0]) begin
          macc <= (mcnt == MCW'(SW - 1)) ? macc - mcs : macc + mcs;
        end
        mcs  <= mcs << 1;
        mp   <= mp >> 1;
        mcnt <= mcnt + 1'b1;
      end
      if (dcnt != DCW'(XW)) begin
        drem <= rem_ge ? XW'(rem2 - {1'b0, dd}) : rem2[XW-1:0];
        dq   <= {dq[XW-2:0], rem_ge};
        dcnt <= dcnt + 1'b1;
      end
      if (ga != gb) begin
        if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + 1'b1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga > gb) begin
          ga <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (valid) begin
          ln   <= job.args.left_num;
          ld   <= job.args.left_den;
          rn   <= job.args.right_num;
          rd   <= job.args.right_den;
          flag <= job.flag;
          err  <= job.err;
          n    <= (job.op == OP_NORM) ? sx(job.args.left_num) : '0;
          d    <= (job.op == OP_NORM) ? sx(job.args.left_den) : '0;
        end
      end
      B_ADD_M1, B_GT_M1: if (mul_done) n <= macc;
      B_ADD_M2:  if (mul_done) n <= n + macc;
      B_ADD_M3:  if (mul_done) d <= macc;
      B_GT_M2: begin
        if (mul_done) begin
          flag <= $signed(n) > $signed(macc);
          n    <= '0;
        end
      end
      B_SUB_GCD: if (gcd_done) t <= gval;
      B_SUB_DIV: if (div_done) t <= quo;
      B_SUB_MUL: if (mul_done) d <= ($signed(macc) <= 0) ? XW'(1) : macc;
      B_SUB_DV1: if (div_done) t <= quo;
      B_SUB_DV2: if (div_done) u <= quo;
      B_SUB_M1:  if (mul_done) n <= macc;
      B_SUB_M2:  if (mul_done) n <= n - macc;
      B_FORM:    if (form_gt && d_m1) n <= '0;
      B_MOD:     if (div_done) n <= remv;
      B_RGCD:    if (gcd_done) t <= gval;
      B_DIVN:    if (div_done) n <= quo;
      B_DIVD:    if (div_done) d <= quo;
      default: begin
        t <= t;
      end
    endcase
  end

endmodule

// File: design/rau_checker.sv
module rau_props (
  input logic          clk,
  input logic          rst,
  input logic          busy,
  input logic          done,
  input rau_pkg::res_t result
);
  import rau_pkg::*;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beats back to back");

  a_reset_clear: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("reset did not clear control");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.error |-> result.res_num == '0 && result.res_den == '0 && !result.cmp_flag)
    else $error("error beat carries data");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.cmp_flag |-> result.res_num == '0 && result.res_den == '0)
    else $error("compare beat carries a fraction");

endmodule

bind rational_arithmetic_unit rau_props u_rau_props (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .done   (done),
  .result (result)
);
